>>> rtl/tds_pkg.sv
`default_nettype none

package tds_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int DELAY_W   = 16;
    localparam int NEXT_W    = 4;
    localparam int TICK_W    = 64;

    localparam logic [SLOT_W-1:0] IDLE_SLOT = '0;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_DELAY = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [DELAY_W-1:0] delay_ticks;
    } req_t;

    typedef struct packed {
        logic              switch_now;
        logic [NEXT_W-1:0] next_task;
        logic              table_full;
        logic [TICK_W-1:0] tick_time;
    } rsp_t;

    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  waddr;
        logic [DELAY_W-1:0] wdata;
        logic [SLOT_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/tds_mem.sv
`default_nettype none

module tds_mem (
    input  wire logic                        clk,
    input  wire tds_pkg::mem_req_t           req,
    output logic [tds_pkg::DELAY_W-1:0]      rd_data
);

    logic [tds_pkg::DELAY_W-1:0] mem [tds_pkg::MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

`default_nettype wire

>>> rtl/tds_ctrl.sv
`default_nettype none

module tds_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire tds_pkg::req_t               item,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output tds_pkg::rsp_t                    res,
    output tds_pkg::mem_req_t                mem_req,
    input  wire logic [tds_pkg::DELAY_W-1:0] rd_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TICK  = 2'd1;
    localparam logic [1:0] S_DSCAN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [tds_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                        pend_reg, pend_next;
    logic [tds_pkg::SLOT_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [tds_pkg::CNT_W-1:0]   total_reg, total_next;
    logic [tds_pkg::SLOT_W-1:0]  run_reg, run_next;
    logic [tds_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic                        sw_reg, sw_next;
    logic                        full_reg, full_next;
    logic                        own_reg, own_next;
    logic                        hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            total_reg    <= tds_pkg::CNT_W'(1);
            run_reg      <= tds_pkg::IDLE_SLOT;
            tick_reg     <= '0;
            sw_reg       <= 1'b0;
            full_reg     <= 1'b0;
            own_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            total_reg    <= total_next;
            run_reg      <= run_next;
            tick_reg     <= tick_next;
            sw_reg       <= sw_next;
            full_reg     <= full_next;
            own_reg      <= own_next;
        end
    end

    assign hit = pend_reg && (rd_data == '0) && (pend_idx_reg != run_reg)
                 && (pend_idx_reg != tds_pkg::IDLE_SLOT);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        total_next    = total_reg;
        run_next      = run_reg;
        tick_next     = tick_reg;
        sw_next       = sw_reg;
        full_next     = full_reg;
        own_next      = own_reg;
        mem_req       = '0;
        item_ready    = (state_reg == S_IDLE);
        res_valid     = (state_reg == S_DONE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    sw_next   = 1'b0;
                    full_next = 1'b0;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    case (item.op)
                        tds_pkg::OP_TICK:
                        begin
                            tick_next  = tick_reg + 1'b1;
                            state_next = S_TICK;
                        end
                        tds_pkg::OP_DELAY:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = run_reg;
                            mem_req.wdata = item.delay_ticks;
                            own_next      = |item.delay_ticks;
                            state_next    = S_DSCAN;
                        end
                        tds_pkg::OP_ADD:
                        begin
                            if (total_reg >= tds_pkg::CNT_W'(tds_pkg::MAX_TASKS))
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = total_reg[tds_pkg::SLOT_W-1:0];
                                mem_req.wdata = '0;
                                total_next    = total_reg + 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                // write back the entry read last cycle while reading the next
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pend_idx_reg;
                    mem_req.wdata = (rd_data == '0) ? rd_data : rd_data - 1'b1;
                end
                if (idx_reg < total_reg)
                begin
                    mem_req.raddr = idx_reg[tds_pkg::SLOT_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[tds_pkg::SLOT_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DSCAN:
            begin
                if (hit)
                begin
                    run_next   = pend_idx_reg;
                    sw_next    = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (idx_reg < total_reg)
                begin
                    mem_req.raddr = idx_reg[tds_pkg::SLOT_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[tds_pkg::SLOT_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // nobody ready: fall back to idle if the caller sleeps
                        if (own_reg)
                        begin
                            sw_next  = 1'b1;
                            run_next = tds_pkg::IDLE_SLOT;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.switch_now = sw_reg;
    assign res.next_task  = tds_pkg::NEXT_W'(run_reg);
    assign res.table_full = full_reg;
    assign res.tick_time  = tick_reg;

endmodule

`default_nettype wire

>>> rtl/task_delay_scheduler.sv
// one beat at a time: a new beat is taken only once the controller has handed the last
// response to the output register; tick and delay beats walk the delay table first, add
// and unused ops do not
// the walk uses the simple dual-port delay memory: a tick reads one entry and writes one
// back per cycle, a delay scan only reads
// reset: asynchronous active-low rst_n; tick count 0, idle task running, one task in the table
`default_nettype none

module task_delay_scheduler (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tds_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tds_pkg::rsp_t       rsp
);

    tds_pkg::mem_req_t           mem_req;
    logic [tds_pkg::DELAY_W-1:0] rd_data;
    logic                        res_valid;
    logic                        res_ready;
    tds_pkg::rsp_t               res;
    logic                        out_valid_reg;
    tds_pkg::rsp_t               out_data_reg;

    tds_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req_valid),
        .item_ready (req_ready),
        .item       (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    tds_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // output register
    assign res_ready = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/tds_checker.sv
`default_nettype none

module tds_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_ready,
    input  wire tds_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_ready,
    input  wire tds_pkg::rsp_t rsp
);

    logic [1:0] open_reg;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // beats accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + {1'b0, req_fire} - {1'b0, rsp_fire};
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> open_reg != 2'd0)
        else $error("response without an accepted request");

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg == 2'd2 |-> !req_ready)
        else $error("more than two beats in flight");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.switch_now && rsp.table_full))
        else $error("switch and table full in one response");

    a_req_ignored_op: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.op != tds_pkg::OP_DELAY && req.op != tds_pkg::OP_ADD
        && req.op != tds_pkg::OP_TICK |=> !req_ready)
        else $error("unused op did not occupy the controller");

endmodule

bind task_delay_scheduler tds_checker u_tds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

>>> sim/task_delay_scheduler_tb.sv
module task_delay_scheduler_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT      = 13;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 25;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    tds_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    tds_pkg::rsp_t rsp;

    // scheduler state as predicted
    logic [tds_pkg::DELAY_W-1:0] sleep_left [tds_pkg::MAX_TASKS] = '{default: '0};
    int                          task_count   = 1;
    int                          current_slot = int'(tds_pkg::IDLE_SLOT);
    logic [tds_pkg::TICK_W-1:0]  tick_total   = '0;

    tds_pkg::req_t pending_reqs  [$];
    tds_pkg::rsp_t expected_rsps [$];

    int req_idle_pct  = IDLE_PCT;
    int rsp_idle_pct  = IDLE_PCT;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    bit req_taken     = 1'b0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    task_delay_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic tds_pkg::rsp_t schedule_step(tds_pkg::req_t beat);
        tds_pkg::rsp_t r;
        bit            picked;
        r      = '0;
        picked = 1'b0;
        case (beat.op)
            tds_pkg::OP_TICK:
            begin
                tick_total = tick_total + 1'b1;
                for (int i = 0; i < task_count; i++)
                    if (sleep_left[i] != '0)
                        sleep_left[i] = sleep_left[i] - 1'b1;
            end
            tds_pkg::OP_DELAY:
            begin
                sleep_left[current_slot] = beat.delay_ticks;
                for (int i = 0; i < task_count; i++)
                begin
                    if (!picked && sleep_left[i] == '0 && i != current_slot
                        && i != int'(tds_pkg::IDLE_SLOT))
                    begin
                        current_slot = i;
                        picked       = 1'b1;
                    end
                end
                // nobody ready: fall back to idle only if the caller sleeps
                if (!picked && beat.delay_ticks != '0)
                begin
                    current_slot = int'(tds_pkg::IDLE_SLOT);
                    picked       = 1'b1;
                end
                r.switch_now = picked;
            end
            tds_pkg::OP_ADD:
            begin
                if (task_count >= tds_pkg::MAX_TASKS)
                    r.table_full = 1'b1;
                else
                begin
                    sleep_left[task_count] = '0;
                    task_count++;
                end
            end
            default:
            begin
            end
        endcase
        r.next_task = tds_pkg::NEXT_W'(current_slot);
        r.tick_time = tick_total;
        return r;
    endfunction

    task automatic offer(input logic [1:0] op, input logic [tds_pkg::DELAY_W-1:0] ticks);
        tds_pkg::req_t beat;
        beat.op          = op;
        beat.delay_ticks = ticks;
        pending_reqs.push_back(beat);
    endtask

    task automatic offer_random(input int count);
        tds_pkg::req_t beat;
        int            pick;
        repeat (count)
        begin
            pick             = $urandom_range(0, 99);
            beat.delay_ticks = tds_pkg::DELAY_W'($urandom);
            if (pick < 45)
                beat.op = tds_pkg::OP_TICK;
            else if (pick < 80)
            begin
                beat.op = tds_pkg::OP_DELAY;
                pick    = $urandom_range(0, 99);
                // short sleeps keep tasks cycling; a rare full-range one
                if (pick < 25)
                    beat.delay_ticks = '0;
                else if (pick < 99)
                    beat.delay_ticks = tds_pkg::DELAY_W'($urandom_range(1, 8));
            end
            else if (pick < 93)
                beat.op = tds_pkg::OP_ADD;
            else
                beat.op = OP_UNUSED;
            pending_reqs.push_back(beat);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= req_idle_pct)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response sink
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        tds_pkg::rsp_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t unexpected rsp beat: expected none actual %h", $time, rsp);
                mismatches++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.switch_now !== want.switch_now)
                begin
                    $display("%0t switch_now: expected %0d actual %0d",
                             $time, want.switch_now, rsp.switch_now);
                    mismatches++;
                end
                if (rsp.next_task !== want.next_task)
                begin
                    $display("%0t next_task: expected %0d actual %0d",
                             $time, want.next_task, rsp.next_task);
                    mismatches++;
                end
                if (rsp.table_full !== want.table_full)
                begin
                    $display("%0t table_full: expected %0d actual %0d",
                             $time, want.table_full, rsp.table_full);
                    mismatches++;
                end
                if (rsp.tick_time !== want.tick_time)
                begin
                    $display("%0t tick_time: expected %0d actual %0d",
                             $time, want.tick_time, rsp.tick_time);
                    mismatches++;
                end
            end
        end
        req_taken = req_valid && req_ready;
        if (req_taken)
            expected_rsps.push_back(schedule_step(req));
        if (req_taken || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);

        // idle alone, zero sleep: stays put
        offer(tds_pkg::OP_DELAY, 16'h0000);
        // idle alone, nonzero sleep: switch back to idle itself
        offer(tds_pkg::OP_DELAY, 16'h0005);
        offer(OP_UNUSED, 16'hFFFF);
        offer(OP_UNUSED, 16'h0000);
        offer(tds_pkg::OP_TICK, 16'hFFFF);
        offer(tds_pkg::OP_ADD, 16'h0000);
        offer(tds_pkg::OP_ADD, 16'hFFFF);
        offer(tds_pkg::OP_DELAY, 16'hFFFF);
        offer(tds_pkg::OP_DELAY, 16'h0003);
        offer(tds_pkg::OP_DELAY, 16'h0000);
        offer(tds_pkg::OP_DELAY, 16'h0002);
        offer(tds_pkg::OP_TICK, 16'h0000);
        offer(tds_pkg::OP_TICK, 16'h0000);
        offer(tds_pkg::OP_TICK, 16'h0000);
        offer(tds_pkg::OP_DELAY, 16'h0000);
        // fill the table, then one refused add
        repeat (14) offer(tds_pkg::OP_ADD, 16'h0000);
        offer(tds_pkg::OP_DELAY, 16'h0001);

        offer_random(600);
        drain();

        // long sink stall while requests keep coming
        hold_requests++;
        offer_random(100);
        drain();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        offer_random(500);
        drain();

        req_idle_pct = IDLE_PCT;
        rsp_idle_pct = IDLE_PCT;
        offer_random(450);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> task_delay_scheduler.f
rtl/tds_pkg.sv
rtl/tds_mem.sv
rtl/tds_ctrl.sv
rtl/task_delay_scheduler.sv
rtl/tds_checker.sv
sim/task_delay_scheduler_tb.sv
